// ===== design/value_noise_terrain_cell_macros.svh =====
// ----------------------------------------------------------------------------
// Value noise terrain cell assertion macros
// Shared concurrent assertion forms for the terrain cell checker.
// ----------------------------------------------------------------------------
`ifndef VALUE_NOISE_TERRAIN_CELL_MACROS_SVH
`define VALUE_NOISE_TERRAIN_CELL_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define VNTC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");

// The consequent must hold in the cycle after the antecedent.
`define VNTC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");

`endif

// ===== design/vntc_pkg.sv =====
// ----------------------------------------------------------------------------
// Value noise terrain cell package
// Types, constants and helper functions shared by the terrain cell modules.
// ----------------------------------------------------------------------------
`default_nettype none

package vntc_pkg;

   localparam int NUM_OCT = 4;

   localparam logic [1:0] OCT_MACRO  = 2'd0;
   localparam logic [1:0] OCT_MID    = 2'd1;
   localparam logic [1:0] OCT_DETAIL = 2'd2;
   localparam logic [1:0] OCT_BASIN  = 2'd3;

   localparam logic [63:0] OCT_SALT [NUM_OCT] = '{
      64'h9E3779B97F4A7C15,
      64'hBF58476D1CE4E5B9,
      64'h94D049BB133111EB,
      64'hD6E8FEB86659FD93
   };

   localparam logic [63:0] HASH_MUL_X = 64'h9E3779B185EBCA87;
   localparam logic [63:0] HASH_MUL_Y = 64'hC2B2AE3D27D4EB4F;
   localparam logic [63:0] MIX_ADD    = 64'h9E3779B97F4A7C15;
   localparam logic [63:0] MIX_MUL1   = 64'hBF58476D1CE4E5B9;
   localparam logic [63:0] MIX_MUL2   = 64'h94D049BB133111EB;

   localparam logic [7:0]  BIAS_MAX    = 8'd196;
   localparam logic [16:0] DIV3_MUL    = 17'd43691;
   localparam int          DIV3_SHIFT  = 17;
   localparam logic [16:0] DIV13_MUL   = 17'd80660;
   localparam int          DIV13_SHIFT = 20;

   localparam logic [1:0] CSR_SEED   = 2'd0;
   localparam logic [1:0] CSR_WIDTH  = 2'd1;
   localparam logic [1:0] CSR_HEIGHT = 2'd2;

   localparam logic [1:0] WATER_DRY     = 2'd0;
   localparam logic [1:0] WATER_DAMP    = 2'd1;
   localparam logic [1:0] WATER_SHALLOW = 2'd2;
   localparam logic [1:0] WATER_DEEP    = 2'd3;

   typedef struct packed {
      logic [NUM_OCT-1:0][7:0] ox;
      logic [NUM_OCT-1:0][7:0] oy;
      logic [7:0]              bias;
   } carry_type;

   typedef struct packed {
      logic mix1;
      logic mix2;
      logic fin;
   } hash_en_type;

   function automatic logic [8:0] oct_size(input logic [1:0] o);
      logic [8:0] s;
      unique case (o)
         OCT_MACRO:  s = 9'd256;
         OCT_MID:    s = 9'd64;
         OCT_DETAIL: s = 9'd16;
         OCT_BASIN:  s = 9'd96;
      endcase
      return s;
   endfunction

   function automatic logic [11:0] cell_index(input logic [15:0] c, input logic [1:0] o);
      logic [27:0] prod;
      logic [11:0] idx;
      prod = 28'(c[15:5]) * 28'(DIV3_MUL);
      unique case (o)
         OCT_MACRO:  idx = 12'(c[15:8]);
         OCT_MID:    idx = 12'(c[15:6]);
         OCT_DETAIL: idx = c[15:4];
         OCT_BASIN:  idx = 12'(prod >> DIV3_SHIFT);
      endcase
      return idx;
   endfunction

   function automatic logic [7:0] cell_offset(input logic [15:0] c, input logic [11:0] idx,
                                             input logic [1:0] o);
      logic [7:0] off;
      unique case (o)
         OCT_MACRO:  off = c[7:0];
         OCT_MID:    off = {2'b00, c[5:0]};
         OCT_DETAIL: off = {4'b0000, c[3:0]};
         OCT_BASIN:  off = 8'(c - ((16'(idx) << 6) + (16'(idx) << 5)));
      endcase
      return off;
   endfunction

   function automatic logic [7:0] scale_down(input logic [15:0] n, input logic [1:0] o);
      logic [27:0] prod;
      logic [7:0]  q;
      prod = 28'(n[15:5]) * 28'(DIV3_MUL);
      unique case (o)
         OCT_MACRO:  q = n[15:8];
         OCT_MID:    q = 8'(n >> 6);
         OCT_DETAIL: q = 8'(n >> 4);
         OCT_BASIN:  q = 8'(prod >> DIV3_SHIFT);
      endcase
      return q;
   endfunction

endpackage

`default_nettype wire

// ===== design/vntc_hash.sv =====
// ----------------------------------------------------------------------------
// Value noise terrain cell corner hash
// Three-stage splitmix64 finalizer returning the low byte of the mixed key.
// ----------------------------------------------------------------------------
`default_nettype none

module vntc_hash (
   input  wire logic                 clock,
   input  wire vntc_pkg::hash_en_type enable,
   input  wire logic [63:0]          key_in,
   output logic      [7:0]           value_out
);

   logic [63:0] a_val, b_val, v_val, c_val, w_val;
   logic [63:0] p0_ff, q0_ff;
   logic [31:0] p1_ff, p2_ff, q1_ff, q2_ff;
   logic [7:0]  value_ff, value_in;

   always_comb begin
      a_val    = key_in + vntc_pkg::MIX_ADD;
      b_val    = a_val ^ (a_val >> 30);
      v_val    = p0_ff + {p1_ff + p2_ff, 32'd0};
      c_val    = v_val ^ (v_val >> 27);
      w_val    = q0_ff + {q1_ff + q2_ff, 32'd0};
      value_in = w_val[7:0] ^ w_val[38:31];
   end

   always_ff @(posedge clock) begin
      if (enable.mix1) begin
         p0_ff <= 64'(b_val[31:0]) * 64'(vntc_pkg::MIX_MUL1[31:0]);
         p1_ff <= 32'(b_val[31:0] * vntc_pkg::MIX_MUL1[63:32]);
         p2_ff <= 32'(b_val[63:32] * vntc_pkg::MIX_MUL1[31:0]);
      end
      if (enable.mix2) begin
         q0_ff <= 64'(c_val[31:0]) * 64'(vntc_pkg::MIX_MUL2[31:0]);
         q1_ff <= 32'(c_val[31:0] * vntc_pkg::MIX_MUL2[63:32]);
         q2_ff <= 32'(c_val[63:32] * vntc_pkg::MIX_MUL2[31:0]);
      end
      if (enable.fin) begin
         value_ff <= value_in;
      end
   end

   assign value_out = value_ff;

endmodule

`default_nettype wire

// ===== design/value_noise_terrain_cell.sv =====
// ----------------------------------------------------------------------------
// Value noise terrain cell
// Per-cell elevation and water class from hashed bilinear value noise.
// ----------------------------------------------------------------------------
// The block takes one cell coordinate per cycle while req_stall is low and
// returns one result per cycle while rsp_stall is low, through the input
// stage, the three-stage splitmix64 multiplier pipeline, the bilinear blends
// and the final scaling. Any stage holding a bubble keeps accepting while a
// stalled result waits in the output register. Configuration writes are
// always ready; a new seed also reaches transactions not yet hashed.
`default_nettype none

module value_noise_terrain_cell (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [15:0] req_cell_x,
   input  wire logic [15:0] req_cell_y,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic      [7:0]  rsp_elevation,
   output logic      [1:0]  rsp_water_class,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [63:0] csr_data
);

   localparam int LAST = 12;

   logic [63:0] seed_ff;
   logic [15:0] width_ff, height_ff;

   logic [LAST:1] en, valid_ff, valid_in;

   logic [11:0] lx_ff [vntc_pkg::NUM_OCT];
   logic [11:0] ly_ff [vntc_pkg::NUM_OCT];
   vntc_pkg::carry_type carry_ff [1:9];
   vntc_pkg::carry_type carry_in;

   logic [63:0] px_ff [vntc_pkg::NUM_OCT][2];
   logic [63:0] py_ff [vntc_pkg::NUM_OCT][2];
   logic [63:0] key   [vntc_pkg::NUM_OCT][2][2];
   logic [7:0]  corner[vntc_pkg::NUM_OCT][2][2];
   vntc_pkg::hash_en_type hash_en;

   logic [15:0] xnum_ff [vntc_pkg::NUM_OCT][2];
   logic [7:0]  xval_ff [vntc_pkg::NUM_OCT][2];
   logic [15:0] ynum_ff [vntc_pkg::NUM_OCT];
   logic [7:0]  sample_ff [vntc_pkg::NUM_OCT];
   logic [11:0] esum_ff, esum_in;
   logic [7:0]  basin10_ff, basin11_ff, elev11_ff, elev11_in;
   logic [28:0] elev_prod;
   logic [8:0]  elev_raw;
   logic [7:0]  rsp_elevation_ff;
   logic [1:0]  rsp_water_class_ff, water_in;

   logic [15:0] cx, cy, dx, dy, dmax;
   logic [14:0] half;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff   <= 64'd0;
         width_ff  <= 16'd1;
         height_ff <= 16'd1;
      end else if (csr_valid) begin
         unique case (csr_index)
            vntc_pkg::CSR_SEED:   seed_ff   <= csr_data;
            vntc_pkg::CSR_WIDTH:  width_ff  <= csr_data[15:0];
            vntc_pkg::CSR_HEIGHT: height_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      en[LAST] = !valid_ff[LAST] || !rsp_stall;
      for (int k = LAST - 1; k >= 1; k--) begin
         en[k] = !valid_ff[k] || en[k+1];
      end
      valid_in[1] = en[1] ? req_valid : valid_ff[1];
      for (int k = 2; k <= LAST; k++) begin
         valid_in[k] = en[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !en[1];

   always_comb begin
      cx   = width_ff >> 1;
      cy   = height_ff >> 1;
      dx   = (req_cell_x >= cx) ? req_cell_x - cx : cx - req_cell_x;
      dy   = (req_cell_y >= cy) ? req_cell_y - cy : cy - req_cell_y;
      dmax = (dx > dy) ? dx : dy;
      half = dmax[15:1];
      carry_in.bias = (half >= 15'(vntc_pkg::BIAS_MAX)) ? 8'd0 :
                      8'(15'(vntc_pkg::BIAS_MAX) - half);
      for (int o = 0; o < vntc_pkg::NUM_OCT; o++) begin
         carry_in.ox[o] = vntc_pkg::cell_offset(req_cell_x,
                             vntc_pkg::cell_index(req_cell_x, 2'(o)), 2'(o));
         carry_in.oy[o] = vntc_pkg::cell_offset(req_cell_y,
                             vntc_pkg::cell_index(req_cell_y, 2'(o)), 2'(o));
      end
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         carry_ff[1] <= carry_in;
         for (int o = 0; o < vntc_pkg::NUM_OCT; o++) begin
            lx_ff[o] <= vntc_pkg::cell_index(req_cell_x, 2'(o));
            ly_ff[o] <= vntc_pkg::cell_index(req_cell_y, 2'(o));
         end
      end
      for (int k = 2; k <= 9; k++) begin
         if (en[k]) begin
            carry_ff[k] <= carry_ff[k-1];
         end
      end
      if (en[2]) begin
         for (int o = 0; o < vntc_pkg::NUM_OCT; o++) begin
            for (int c = 0; c < 2; c++) begin
               px_ff[o][c] <= (64'(lx_ff[o]) + 64'(c)) * vntc_pkg::HASH_MUL_X;
               py_ff[o][c] <= (64'(ly_ff[o]) + 64'(c)) * vntc_pkg::HASH_MUL_Y;
            end
         end
      end
   end

   assign hash_en = '{mix1: en[3], mix2: en[4], fin: en[5]};

   for (genvar o = 0; o < vntc_pkg::NUM_OCT; o++) begin : g_oct
      for (genvar j = 0; j < 2; j++) begin : g_row
         for (genvar i = 0; i < 2; i++) begin : g_col
            assign key[o][j][i] = seed_ff ^ vntc_pkg::OCT_SALT[o] ^ px_ff[o][i] ^ py_ff[o][j];
            vntc_hash u_hash (
               .clock     (clock),
               .enable    (hash_en),
               .key_in    (key[o][j][i]),
               .value_out (corner[o][j][i])
            );
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int o = 0; o < vntc_pkg::NUM_OCT; o++) begin
         for (int j = 0; j < 2; j++) begin
            if (en[6]) begin
               xnum_ff[o][j] <= 16'(
                  17'(corner[o][j][0]) *
                     17'(vntc_pkg::oct_size(2'(o)) - {1'b0, carry_ff[5].ox[o]}) +
                  17'(corner[o][j][1]) * 17'(carry_ff[5].ox[o]));
            end
            if (en[7]) begin
               xval_ff[o][j] <= vntc_pkg::scale_down(xnum_ff[o][j], 2'(o));
            end
         end
         if (en[8]) begin
            ynum_ff[o] <= 16'(
               17'(xval_ff[o][0]) *
                  17'(vntc_pkg::oct_size(2'(o)) - {1'b0, carry_ff[7].oy[o]}) +
               17'(xval_ff[o][1]) * 17'(carry_ff[7].oy[o]));
         end
         if (en[9]) begin
            sample_ff[o] <= vntc_pkg::scale_down(ynum_ff[o], 2'(o));
         end
      end
   end

   always_comb begin
      esum_in = 12'(sample_ff[vntc_pkg::OCT_MACRO]) * 12'd5 +
                12'(sample_ff[vntc_pkg::OCT_MID]) * 12'd3 +
                12'(sample_ff[vntc_pkg::OCT_DETAIL]) +
                (12'(carry_ff[9].bias) << 2);
      elev_prod = 29'(esum_ff) * 29'(vntc_pkg::DIV13_MUL);
      elev_raw  = 9'(elev_prod >> vntc_pkg::DIV13_SHIFT);
      elev11_in = elev_raw[8] ? 8'd255 : elev_raw[7:0];
      priority if (elev11_ff < 8'd28 || (elev11_ff < 8'd36 && basin11_ff > 8'd150)) begin
         water_in = vntc_pkg::WATER_DEEP;
      end else if (elev11_ff < 8'd42 || (elev11_ff < 8'd54 && basin11_ff > 8'd180)) begin
         water_in = vntc_pkg::WATER_SHALLOW;
      end else if (elev11_ff < 8'd64 || basin11_ff > 8'd235) begin
         water_in = vntc_pkg::WATER_DAMP;
      end else begin
         water_in = vntc_pkg::WATER_DRY;
      end
   end

   always_ff @(posedge clock) begin
      if (en[10]) begin
         esum_ff    <= esum_in;
         basin10_ff <= sample_ff[vntc_pkg::OCT_BASIN];
      end
      if (en[11]) begin
         elev11_ff  <= elev11_in;
         basin11_ff <= basin10_ff;
      end
      if (en[12]) begin
         rsp_elevation_ff   <= elev11_ff;
         rsp_water_class_ff <= water_in;
      end
   end

   assign rsp_valid       = valid_ff[LAST];
   assign rsp_elevation   = rsp_elevation_ff;
   assign rsp_water_class = rsp_water_class_ff;

endmodule

`default_nettype wire

// ===== design/vntc_checker.sv =====
// ----------------------------------------------------------------------------
// Value noise terrain cell checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "value_noise_terrain_cell_macros.svh"

module vntc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [7:0]  rsp_elevation,
   input wire logic [1:0]  rsp_water_class
);

   `VNTC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `VNTC_ASSERT_NEXT(a_elev_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_elevation))
   `VNTC_ASSERT_NEXT(a_water_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_water_class))
   `VNTC_ASSERT_SAME(a_dry_high, clock, reset, rsp_valid && rsp_water_class == vntc_pkg::WATER_DRY, rsp_elevation >= 8'd64)
   `VNTC_ASSERT_SAME(a_low_deep, clock, reset, rsp_valid && rsp_elevation < 8'd28, rsp_water_class == vntc_pkg::WATER_DEEP)

endmodule

bind value_noise_terrain_cell vntc_checker u_vntc_checker (.*);

`default_nettype wire

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// Value noise terrain cell testbench
// Streams cell coordinates through the block under several seeds and map
// sizes, predicts elevation and water class for each transaction, and checks
// every result in order while both sides idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module testbench;

   localparam int WATCHDOG_LIMIT = 20000;

   typedef struct packed {
      logic [15:0] x;
      logic [15:0] y;
   } coord_type;

   typedef struct packed {
      logic [7:0] elevation;
      logic [1:0] water_class;
   } terrain_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_cell_x = '0;
   logic [15:0] req_cell_y = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_elevation;
   logic [1:0]  rsp_water_class;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = vntc_pkg::CSR_SEED;
   logic [63:0] csr_data = '0;

   logic [63:0] seed_reg = '0;
   logic [15:0] width_reg = 16'd1;
   logic [15:0] height_reg = 16'd1;

   coord_type   pending_cells[$];
   terrain_type expected_terrain[$];
   int          error_count = 0;
   int          checked_count = 0;
   int          idle_cycles = 0;
   int          burst_left = 0;
   int          gap_left = 0;
   int          hold_off = 0;
   bit          hold_off_request = 1'b0;
   int          config_count = 0;

   value_noise_terrain_cell i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_cell_x(req_cell_x), .req_cell_y(req_cell_y),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_elevation(rsp_elevation), .rsp_water_class(rsp_water_class),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #4 clock = ~clock;

   function automatic logic [63:0] splitmix(input logic [63:0] v);
      v = v + 64'h9E3779B97F4A7C15;
      v = (v ^ (v >> 30)) * 64'hBF58476D1CE4E5B9;
      v = (v ^ (v >> 27)) * 64'h94D049BB133111EB;
      return v ^ (v >> 31);
   endfunction

   function automatic int unsigned corner_hash(input logic [63:0] s, input int unsigned lx,
                                               input int unsigned ly);
      logic [63:0] h;
      h = s ^ (64'(lx) * 64'h9E3779B185EBCA87) ^ (64'(ly) * 64'hC2B2AE3D27D4EB4F);
      return 32'(splitmix(h) & 64'hFF);
   endfunction

   function automatic int unsigned lerp_div(input int unsigned a, input int unsigned b,
                                            input int unsigned n, input int unsigned d);
      return (a * (d - n) + b * n) / d;
   endfunction

   function automatic int unsigned value_noise(input logic [63:0] s, input int unsigned x,
                                               input int unsigned y, input int unsigned size);
      int unsigned lx, ly, ox, oy, top, bot;
      lx = x / size;
      ly = y / size;
      ox = x % size;
      oy = y % size;
      top = lerp_div(corner_hash(s, lx, ly), corner_hash(s, lx + 1, ly), ox, size);
      bot = lerp_div(corner_hash(s, lx, ly + 1), corner_hash(s, lx + 1, ly + 1), ox, size);
      return lerp_div(top, bot, oy, size);
   endfunction

   function automatic terrain_type predict_terrain(input coord_type c);
      int unsigned x, y, macro_n, mid_n, detail_n, basin, dx, dy, d, bias, e, cx, cy;
      terrain_type t;
      x = c.x;
      y = c.y;
      macro_n = value_noise(seed_reg ^ 64'h9E3779B97F4A7C15, x, y, 256);
      mid_n = value_noise(seed_reg ^ 64'hBF58476D1CE4E5B9, x, y, 64);
      detail_n = value_noise(seed_reg ^ 64'h94D049BB133111EB, x, y, 16);
      cx = width_reg / 2;
      cy = height_reg / 2;
      dx = x > cx ? x - cx : cx - x;
      dy = y > cy ? y - cy : cy - y;
      d = dx > dy ? dx : dy;
      bias = d / 2 >= 196 ? 0 : 196 - d / 2;
      e = (macro_n * 5 + mid_n * 3 + detail_n + bias * 4) / 13;
      if (e > 255) e = 255;
      t.elevation = 8'(e);
      basin = value_noise(seed_reg ^ 64'hD6E8FEB86659FD93, x, y, 96);
      if (e < 28 || (e < 36 && basin > 150)) t.water_class = vntc_pkg::WATER_DEEP;
      else if (e < 42 || (e < 54 && basin > 180)) t.water_class = vntc_pkg::WATER_SHALLOW;
      else if (e < 64 || basin > 235) t.water_class = vntc_pkg::WATER_DAMP;
      else t.water_class = vntc_pkg::WATER_DRY;
      return t;
   endfunction

   task automatic write_register(input logic [1:0] idx, input logic [63:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         vntc_pkg::CSR_SEED: seed_reg = value;
         vntc_pkg::CSR_WIDTH: width_reg = value[15:0];
         vntc_pkg::CSR_HEIGHT: height_reg = value[15:0];
         default: ;
      endcase
      config_count++;
   endtask

   task automatic wait_drained();
      wait (pending_cells.size() == 0 && expected_terrain.size() == 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic queue_cell(input logic [15:0] x, input logic [15:0] y);
      pending_cells.push_back({x, y});
   endtask

   task automatic queue_random_cells(input int count, input int unsigned span);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3) == 0) queue_cell(16'($urandom), 16'($urandom));
         else queue_cell(16'($urandom_range(span)), 16'($urandom_range(span)));
      end
   endtask

   // Driver: bursts of random length separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && req_stall)) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_cells.size() > 0) begin
            coord_type c;
            c = pending_cells.pop_front();
            req_valid <= 1'b1;
            req_cell_x <= c.x;
            req_cell_y <= c.y;
            expected_terrain.push_back(predict_terrain(c));
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(30);
               gap_left = $urandom_range(3) == 0 ? 0 : $urandom_range(6);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver stall pattern plus an occasional long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off_request && hold_off == 0) begin
         hold_off_request = 1'b0;
         hold_off = 60;
         rsp_stall <= 1'b1;
      end else if (hold_off > 0) begin
         hold_off--;
         rsp_stall <= hold_off > 0;
      end else begin
         case (($urandom_range(255) >> 6))
            0: rsp_stall <= 1'b1;
            1: rsp_stall <= 1'($urandom_range(1));
            default: rsp_stall <= 1'b0;
         endcase
      end
   end

   // Monitor: checks each accepted transaction and runs the watchdog.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_valid)
            idle_cycles = 0;
         else
            idle_cycles++;
         if (rsp_valid && !rsp_stall) begin
            if (expected_terrain.size() == 0) begin
               $error("result with no transaction outstanding: elevation %0d water %0d",
                      rsp_elevation, rsp_water_class);
               error_count++;
            end else begin
               terrain_type t;
               t = expected_terrain.pop_front();
               if (rsp_elevation !== t.elevation) begin
                  $error("elevation expected %0d actual %0d", t.elevation, rsp_elevation);
                  error_count++;
               end
               if (rsp_water_class !== t.water_class) begin
                  $error("water_class expected %0d actual %0d", t.water_class,
                         rsp_water_class);
                  error_count++;
               end
               checked_count++;
            end
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding",
                     expected_terrain.size());
            $display("FAIL value_noise_terrain_cell");
            $finish;
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Reset settings: seed 0 and a one-cell map, then the field extremes.
      queue_cell(16'd0, 16'd0);
      queue_cell(16'hFFFF, 16'hFFFF);
      queue_cell(16'hFFFF, 16'd0);
      queue_cell(16'd0, 16'hFFFF);
      queue_cell(16'h5555, 16'hAAAA);
      queue_cell(16'hAAAA, 16'h5555);
      wait_drained();

      write_register(vntc_pkg::CSR_SEED, 64'hFFFF_FFFF_FFFF_FFFF);
      write_register(vntc_pkg::CSR_WIDTH, 64'd0);
      write_register(vntc_pkg::CSR_HEIGHT, 64'd0);
      queue_cell(16'd0, 16'd0);
      queue_cell(16'd1, 16'd1);
      queue_cell(16'd255, 16'd256);
      queue_cell(16'd95, 16'd96);
      queue_cell(16'd63, 16'd64);
      queue_cell(16'd15, 16'd16);
      queue_cell(16'd391, 16'd392);
      queue_cell(16'hFFFF, 16'hFFFF);
      wait_drained();

      write_register(vntc_pkg::CSR_SEED, 64'h0123_4567_89AB_CDEF);
      write_register(vntc_pkg::CSR_WIDTH, 64'hFFFF);
      write_register(vntc_pkg::CSR_HEIGHT, 64'hFFFF);
      queue_cell(16'h7FFF, 16'h7FFF);
      queue_cell(16'h8000, 16'h7FFF);
      queue_cell(16'h7E00, 16'h7F80);
      queue_cell(16'h0000, 16'h7FFF);
      queue_cell(16'hFFFF, 16'h0000);
      wait_drained();

      // A long hold-off while the sender keeps offering coordinates.
      write_register(vntc_pkg::CSR_WIDTH, 64'd200);
      write_register(vntc_pkg::CSR_HEIGHT, 64'd160);
      queue_random_cells(80, 300);
      hold_off_request = 1'b1;
      queue_random_cells(120, 300);
      wait_drained();

      for (int phase = 0; phase < 5; phase++) begin
         int unsigned w, h;
         w = phase == 0 ? 1 : $urandom_range(65535);
         h = phase == 4 ? 65535 : $urandom_range(1, 1024);
         write_register(vntc_pkg::CSR_SEED, {$urandom, $urandom});
         write_register(vntc_pkg::CSR_WIDTH, 64'(w));
         write_register(vntc_pkg::CSR_HEIGHT, 64'(h));
         queue_random_cells(120, w > h ? w : h);
         wait_drained();
      end

      $display("checked %0d results over %0d register writes", checked_count, config_count);
      $display("covered seed, map size extremes, lattice edges and long output stalls");
      if (error_count == 0)
         $display("PASS value_noise_terrain_cell");
      else
         $display("FAIL value_noise_terrain_cell");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+design
design/vntc_pkg.sv
design/vntc_hash.sv
design/value_noise_terrain_cell.sv
design/vntc_checker.sv
test/testbench.sv
